/* rtl/mkd_pkg.sv */
// Shared types, constants and the letter lookup for the Morse key decoder.
// Used by the decoder core and the port checks; depends on nothing else.
`default_nettype none

package mkd_pkg;

  // Field and counter widths.
  localparam int CNT_W  = 12;
  localparam int CODE_W = 7;
  localparam int BITS_W = 6;
  localparam int SCNT_W = 3;

  localparam logic [CNT_W-1:0]  CNT_MAX     = '1;
  localparam logic [SCNT_W-1:0] MAX_SYMBOLS = 3'd5;

  // Register reset values.
  localparam logic [CNT_W-1:0] DOT_THRESHOLD_RST = 12'd20;
  localparam logic [CNT_W-1:0] CHAR_GAP_RST      = 12'd60;
  localparam logic [CNT_W-1:0] WORD_GAP_RST      = 12'd120;

  // Character codes.
  localparam logic [CODE_W-1:0] ASCII_A     = 7'h41;
  localparam logic [CODE_W-1:0] ASCII_QMARK = 7'h3F;
  localparam logic [CODE_W-1:0] ASCII_SPACE = 7'h20;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_DOT_THRESHOLD = 2'd0,
    REG_CHAR_GAP      = 2'd1,
    REG_WORD_GAP      = 2'd2,
    REG_NONE          = 2'd3
  } mkd_reg_idx_t;

  // One result word.
  typedef struct packed {
    logic              char_valid;
    logic [CODE_W-1:0] char_code;
    logic              lamp;
  } mkd_result_t;

  // Letter table: symbol pattern (first symbol highest, dash = 1) and length.
  localparam logic [BITS_W-1:0] LETTER_BITS [26] = '{
    6'd1, 6'd8, 6'd10, 6'd4, 6'd0, 6'd2, 6'd6, 6'd0, 6'd0, 6'd7, 6'd5, 6'd4, 6'd3,
    6'd2, 6'd7, 6'd6, 6'd13, 6'd2, 6'd0, 6'd1, 6'd1, 6'd1, 6'd3, 6'd9, 6'd11, 6'd12};
  localparam logic [SCNT_W-1:0] LETTER_LEN [26] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4};

  // Every pattern in the table is distinct, so the matches are simply ORed.
  function automatic logic [CODE_W-1:0] mkd_lookup(input logic [BITS_W-1:0] bits,
                                                   input logic [SCNT_W-1:0] cnt);
    logic [CODE_W-1:0] code;
    logic              found;
    code  = '0;
    found = 1'b0;
    for (int i = 0; i < 26; i++) begin
      if (LETTER_LEN[i] == cnt && LETTER_BITS[i] == bits) begin
        code  = code | (ASCII_A + CODE_W'(i));
        found = 1'b1;
      end
    end
    if (!found) begin
      code = ASCII_QMARK;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

/* rtl/mkd_skid.sv */
// Two-entry output buffer that holds result words while the receiver stalls.
// Generic in width; depends on nothing else.
`default_nettype none

module mkd_skid #(
  parameter int WIDTH = 9
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [WIDTH-1:0]      out_data
);

  logic             main_valid_r, main_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  logic [WIDTH-1:0] main_data_r, main_data_nxt;
  logic [WIDTH-1:0] skid_data_r, skid_data_nxt;
  logic             push;
  logic             pop;

  // The skid entry is only filled while the main entry waits, so a full skid stalls input.
  assign in_stall  = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;
  assign push      = in_valid && !skid_valid_r;
  assign pop       = main_valid_r && !out_stall;

  // Next-state of the two entries.
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_data_nxt  = main_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_data_nxt  = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!main_valid_r || pop) begin
      main_valid_nxt = push;
      if (push) begin
        main_data_nxt = in_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

`default_nettype wire

/* rtl/morse_key_decoder_core.sv */
// Morse key decoder: one sampled key level per word in, one result word out.
//
// The input channel (in_valid, in_stall, in_key_down) carries one key sample per
// tick. Each accepted word yields exactly one result word on the output channel
// (out_valid, out_stall, out_char_valid, out_char_code, out_lamp): a flag and
// ASCII code when a letter, '?' or a word-gap space is emitted, and the lamp level.
// The three timing registers are written over the APB-style port at byte
// addresses 0x0 (dot threshold), 0x4 (character gap) and 0x8 (word gap).
//
// The whole tick is evaluated combinationally from the state registers, so a word
// can be accepted every cycle while in_stall is low; its result is
// registered in a two-entry output buffer: while the receiver stalls, one more
// word is still accepted, and in_stall rises only when both entries are full.
// Reset clears the decoder state and the buffer and loads the default timing
// (20, 60 and 120 ticks); no result is pending after reset.
// Depends on mkd_pkg and mkd_skid.
`default_nettype none

module morse_key_decoder_core
  import mkd_pkg::*;
#(
  parameter logic [SCNT_W-1:0] SYMBOL_MAX = MAX_SYMBOLS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_key_down,
  // Output channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_char_valid,
  output logic [CODE_W-1:0]      out_char_code,
  output logic                   out_lamp,
  // Configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // Configuration registers.
  logic [CNT_W-1:0] dot_threshold_r;
  logic [CNT_W-1:0] char_gap_r;
  logic [CNT_W-1:0] word_gap_r;
  mkd_reg_idx_t     reg_idx;
  logic             cfg_write;

  // Decoder state.
  logic [CNT_W-1:0]  press_ticks_r, press_ticks_nxt;
  logic [CNT_W-1:0]  gap_ticks_r, gap_ticks_nxt;
  logic              in_press_r, in_press_nxt;
  logic              holdoff_r, holdoff_nxt;
  logic [BITS_W-1:0] symbol_bits_r, symbol_bits_nxt;
  logic [SCNT_W-1:0] symbol_count_r, symbol_count_nxt;
  logic              lamp_r, lamp_nxt;

  mkd_result_t       result;
  mkd_result_t       out_word;
  logic              accept;
  logic              dash;

  assign pready    = 1'b1;
  assign reg_idx   = mkd_reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_threshold_r <= DOT_THRESHOLD_RST;
      char_gap_r      <= CHAR_GAP_RST;
      word_gap_r      <= WORD_GAP_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_DOT_THRESHOLD: dot_threshold_r <= pwdata[CNT_W-1:0];
        REG_CHAR_GAP:      char_gap_r      <= pwdata[CNT_W-1:0];
        REG_WORD_GAP:      word_gap_r      <= pwdata[CNT_W-1:0];
        REG_NONE:          ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_idx)
      REG_DOT_THRESHOLD: prdata = {{(32-CNT_W){1'b0}}, dot_threshold_r};
      REG_CHAR_GAP:      prdata = {{(32-CNT_W){1'b0}}, char_gap_r};
      REG_WORD_GAP:      prdata = {{(32-CNT_W){1'b0}}, word_gap_r};
      REG_NONE:          prdata = '0;
    endcase
  end

  assign dash = (dot_threshold_r != '0) && (press_ticks_r >= dot_threshold_r);

  // One tick of the decoder. The gap checks run in order; only the first
  // emission is reported, but every check still updates the state.
  always_comb begin
    logic run_checks;
    press_ticks_nxt  = press_ticks_r;
    gap_ticks_nxt    = gap_ticks_r;
    in_press_nxt     = in_press_r;
    holdoff_nxt      = holdoff_r;
    symbol_bits_nxt  = symbol_bits_r;
    symbol_count_nxt = symbol_count_r;
    lamp_nxt         = lamp_r;
    result           = '0;
    run_checks       = 1'b0;

    if (holdoff_r) begin
      // Debounce tick after release: append the symbol.
      holdoff_nxt      = 1'b0;
      symbol_bits_nxt  = {symbol_bits_r[BITS_W-2:0], dash};
      symbol_count_nxt = symbol_count_r + 3'd1;
      gap_ticks_nxt    = '0;
      run_checks       = 1'b1;
    end else if (in_press_r) begin
      if (in_key_down) begin
        if (press_ticks_r < CNT_MAX) begin
          press_ticks_nxt = press_ticks_r + 12'd1;
        end
        if (press_ticks_nxt == dot_threshold_r) begin
          lamp_nxt = 1'b1;
        end
      end else begin
        lamp_nxt     = 1'b0;
        in_press_nxt = 1'b0;
        holdoff_nxt  = 1'b1;
      end
    end else begin
      if (gap_ticks_r < CNT_MAX) begin
        gap_ticks_nxt = gap_ticks_r + 12'd1;
      end
      if (in_key_down) begin
        lamp_nxt        = (dot_threshold_r == 12'd1);
        in_press_nxt    = 1'b1;
        press_ticks_nxt = 12'd1;
      end else begin
        run_checks = 1'b1;
      end
    end

    if (run_checks) begin
      // Too many symbols for any letter.
      if (symbol_count_nxt > SYMBOL_MAX) begin
        lamp_nxt          = 1'b0;
        gap_ticks_nxt     = '0;
        result.char_valid = 1'b1;
        result.char_code  = ASCII_QMARK;
        symbol_bits_nxt   = '0;
        symbol_count_nxt  = '0;
      end
      // Character gap: decode what has been gathered.
      if (gap_ticks_nxt == char_gap_r) begin
        lamp_nxt = 1'b1;
        if (symbol_count_nxt != '0 && !result.char_valid) begin
          result.char_valid = 1'b1;
          result.char_code  = mkd_lookup(symbol_bits_nxt, symbol_count_nxt);
        end
        symbol_bits_nxt  = '0;
        symbol_count_nxt = '0;
      end
      // Word gap: emit a space.
      if (gap_ticks_nxt >= word_gap_r) begin
        lamp_nxt = 1'b0;
        if (!result.char_valid) begin
          result.char_valid = 1'b1;
          result.char_code  = ASCII_SPACE;
        end
        gap_ticks_nxt = '0;
      end
    end

    result.lamp = lamp_nxt;
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_ticks_r  <= '0;
      gap_ticks_r    <= '0;
      in_press_r     <= 1'b0;
      holdoff_r      <= 1'b0;
      symbol_bits_r  <= '0;
      symbol_count_r <= '0;
      lamp_r         <= 1'b0;
    end else if (accept) begin
      press_ticks_r  <= press_ticks_nxt;
      gap_ticks_r    <= gap_ticks_nxt;
      in_press_r     <= in_press_nxt;
      holdoff_r      <= holdoff_nxt;
      symbol_bits_r  <= symbol_bits_nxt;
      symbol_count_r <= symbol_count_nxt;
      lamp_r         <= lamp_nxt;
    end
  end

  // Output buffer.
  mkd_skid #(
    .WIDTH($bits(mkd_result_t))
  ) u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (result),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_word)
  );

  assign out_char_valid = out_word.char_valid;
  assign out_char_code  = out_word.char_code;
  assign out_lamp       = out_word.lamp;

endmodule

`default_nettype wire

/* rtl/mkd_checker.sv */
// Port-level checks on the Morse key decoder, bound to its top level.
// Depends on mkd_pkg and morse_key_decoder_core.
`default_nettype none

module mkd_port_checks
  import mkd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              out_char_valid,
  input wire logic [CODE_W-1:0] out_char_code,
  input wire logic              out_lamp
);

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word pending after reset");

  // The input only stalls when a result was already waiting on a stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // An empty output buffer never stalls the input.
  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_valid)
      && $stable(out_char_code) && $stable(out_lamp))
    else $error("stalled result word changed");

  // A word without a character carries a zero code.
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_char_valid |-> out_char_code == '0)
    else $error("character code set without a character");

endmodule

bind morse_key_decoder_core mkd_port_checks u_mkd_port_checks (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_char_valid(out_char_valid),
  .out_char_code (out_char_code),
  .out_lamp      (out_lamp)
);

`default_nettype wire
